[hw/rtl/jtdt_pkg.sv]
// Shared types, constants and the TAP transition function for the JTAG debug transport.
// No dependencies; every other file in hw/rtl refers to this package by scoped names.
package jtdt_pkg;

  localparam int IR_WIDTH   = 5;
  localparam int ADDR_WIDTH = 6;
  localparam int DATA_W     = 32;
  localparam int PL_W       = 64;
  localparam int CNT_W      = 7;

  // Command opcodes
  localparam logic [2:0] OP_RESET     = 3'd0;
  localparam logic [2:0] OP_TMS_SEQ   = 3'd1;
  localparam logic [2:0] OP_SCAN      = 3'd2;
  localparam logic [2:0] OP_SCAN_FLIP = 3'd3;
  localparam logic [2:0] OP_BUS_RESP  = 3'd4;

  // Result kinds
  localparam logic [1:0] KIND_SCAN  = 2'd0;
  localparam logic [1:0] KIND_REQ   = 2'd1;
  localparam logic [1:0] KIND_UNEXP = 2'd2;

  // Debug bus ops
  localparam logic [1:0] BOP_NOP      = 2'd0;
  localparam logic [1:0] BOP_READ     = 2'd1;
  localparam logic [1:0] BOP_WRITE    = 2'd2;

  // TAP states used by name
  localparam logic [3:0] TAP_RESET    = 4'd0;
  localparam logic [3:0] TAP_SHIFT_DR = 4'd4;
  localparam logic [3:0] TAP_SHIFT_IR = 4'd11;

  // Instructions
  localparam logic [IR_WIDTH-1:0] INSTR_IDCODE = 5'h01;
  localparam logic [IR_WIDTH-1:0] INSTR_DTMCS  = 5'h10;
  localparam logic [IR_WIDTH-1:0] INSTR_DBUS   = 5'h11;

  // Scan lengths: the two IR lengths load the instruction register; SCAN_LEN is the full scan
  localparam logic [CNT_W-1:0] IR_SCAN_LEN      = 7'd5;
  localparam logic [CNT_W-1:0] IR_SCAN_LEN_LONG = 7'd7;
  localparam logic [CNT_W-1:0] SCAN_LEN         = 7'd64;

  // Configuration registers
  localparam logic [DATA_W-1:0] ID_CODE_RESET   = 32'h0000_0ffd;
  localparam logic [DATA_W-1:0] CTRL_WORD_RESET = 32'h0000_0061;
  localparam logic              REG_ID_CODE     = 1'b0;
  localparam logic              REG_CTRL_WORD   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TMS,
    ST_SCAN,
    ST_EMIT
  } ctl_state_t;

  // Start request from the controller to the bit shifter
  typedef struct packed {
    logic              start;
    logic [CNT_W-1:0]  cnt;
    logic [DATA_W-1:0] word;
    logic              off2;
    logic              hi_en;
    logic [CNT_W-1:0]  bits;
  } eng_ctl_t;

  // Status of the bit shifter
  typedef struct packed {
    logic active;
    logic tms_bit;
  } eng_sts_t;

  // Standard TAP controller transition
  function automatic logic [3:0] tap_step(input logic [3:0] st, input logic tms);
    logic [3:0] nxt;
    begin
      case (st)
        4'd0:    nxt = tms ? 4'd0  : 4'd1;
        4'd1:    nxt = tms ? 4'd2  : 4'd1;
        4'd2:    nxt = tms ? 4'd9  : 4'd3;
        4'd3:    nxt = tms ? 4'd5  : 4'd4;
        4'd4:    nxt = tms ? 4'd5  : 4'd4;
        4'd5:    nxt = tms ? 4'd8  : 4'd6;
        4'd6:    nxt = tms ? 4'd7  : 4'd6;
        4'd7:    nxt = tms ? 4'd8  : 4'd4;
        4'd8:    nxt = tms ? 4'd2  : 4'd1;
        4'd9:    nxt = tms ? 4'd0  : 4'd10;
        4'd10:   nxt = tms ? 4'd12 : 4'd11;
        4'd11:   nxt = tms ? 4'd12 : 4'd11;
        4'd12:   nxt = tms ? 4'd15 : 4'd13;
        4'd13:   nxt = tms ? 4'd14 : 4'd13;
        4'd14:   nxt = tms ? 4'd15 : 4'd11;
        4'd15:   nxt = tms ? 4'd2  : 4'd1;
        default: nxt = 4'd0;
      endcase
      return nxt;
    end
  endfunction

endpackage

[hw/rtl/jtdt_if.sv]
// Valid/ready channel interfaces for host commands and results.
// Depends on jtdt_pkg for field widths.
interface jtdt_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    opcode;
  logic [jtdt_pkg::CNT_W-1:0]    bit_count;
  logic [jtdt_pkg::PL_W-1:0]     payload;

  modport source(output valid, output opcode, output bit_count, output payload, input ready);
  modport sink(input valid, input opcode, input bit_count, input payload, output ready);
endinterface

interface jtdt_res_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         result_kind;
  logic [jtdt_pkg::PL_W-1:0]          scan_reply;
  logic [jtdt_pkg::ADDR_WIDTH-1:0]    bus_addr;
  logic [jtdt_pkg::DATA_W-1:0]        bus_data;
  logic [1:0]                         bus_op;

  modport source(output valid, output result_kind, output scan_reply, output bus_addr,
                 output bus_data, output bus_op, input ready);
  modport sink(input valid, input result_kind, input scan_reply, input bus_addr,
               input bus_data, input bus_op, output ready);
endinterface

[hw/rtl/jtag_tap_debug_transport_unit.sv]
// Top level of the JTAG TAP debug transport: APB registers, sequencer and bit shifter.
// Depends on jtdt_pkg, jtdt_if, jtdt_apb_regs, jtdt_shift_engine and jtdt_ctrl.
//
//   channel   dir  handshake       payload
//   cmd       in   valid/ready     opcode[2:0], bit_count[6:0], payload[63:0]
//   res       out  valid/ready     result_kind[1:0], scan_reply[63:0], bus_addr[5:0],
//                                  bus_data[31:0], bus_op[1:0]
//   apb       in   psel/penable    paddr[2:0], pwdata[31:0], prdata[31:0], pready
//
// Reset, dropped items and zero-length TMS runs end in IDLE; a bus request or stray response
// goes straight to EMIT. A TMS sequence makes one TAP step per cycle from the shifter's bits.
// Scan and bus response shift the reply through the shifter, one reply bit a cycle, then EMIT.
// rst is synchronous; no memory, so the block accepts items right after reset.
// One result register: a new command is taken while the previous result waits; a second
// result stalls in the sequencer until the first is taken.
module jtag_tap_debug_transport_unit #(
  parameter int MAX_TMS_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  jtdt_cmd_if.sink    cmd,
  jtdt_res_if.source  res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0]                id_code;
  logic [31:0]                ctrl_word;
  jtdt_pkg::eng_ctl_t         eng_ctl;
  jtdt_pkg::eng_sts_t         eng_sts;
  logic [jtdt_pkg::PL_W-1:0]  eng_reply;

  jtdt_apb_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .id_code   (id_code),
    .ctrl_word (ctrl_word)
  );

  jtdt_shift_engine u_shift (
    .clk   (clk),
    .rst   (rst),
    .ctl   (eng_ctl),
    .pl    (cmd.payload),
    .sts   (eng_sts),
    .reply (eng_reply)
  );

  jtdt_ctrl #(
    .MAX_TMS_BITS (MAX_TMS_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .res       (res),
    .id_code   (id_code),
    .ctrl_word (ctrl_word),
    .eng_sts   (eng_sts),
    .eng_reply (eng_reply),
    .eng_ctl   (eng_ctl)
  );

endmodule

[hw/rtl/jtdt_apb_regs.sv]
// APB configuration registers: IDCODE value and DTM control word.
// Depends on jtdt_pkg for reset values and register selects.
module jtdt_apb_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [31:0] id_code,
  output logic [31:0] ctrl_word
);

  logic wr_en;

  // Write on the access phase; byte offset bits are ignored
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      id_code   <= jtdt_pkg::ID_CODE_RESET;
      ctrl_word <= jtdt_pkg::CTRL_WORD_RESET;
    end else if (wr_en) begin
      if (paddr[2] == jtdt_pkg::REG_CTRL_WORD) begin
        ctrl_word <= pwdata;
      end else begin
        id_code <= pwdata;
      end
    end
  end

  // Read back
  assign prdata = (paddr[2] == jtdt_pkg::REG_ID_CODE) ? id_code : ctrl_word;

endmodule

[hw/rtl/jtdt_shift_engine.sv]
// Bit-serial shifter: walks the payload one bit per cycle and builds the scan reply.
// Depends on jtdt_pkg for the control and status structs.
module jtdt_shift_engine (
  input  logic                      clk,
  input  logic                      rst,
  input  jtdt_pkg::eng_ctl_t        ctl,
  input  logic [jtdt_pkg::PL_W-1:0] pl,
  output jtdt_pkg::eng_sts_t        sts,
  output logic [jtdt_pkg::PL_W-1:0] reply
);

  logic                         active;
  logic [jtdt_pkg::CNT_W-1:0]   left;
  logic [5:0]                   idx;
  logic [jtdt_pkg::PL_W-1:0]    pshift;
  logic [jtdt_pkg::DATA_W-1:0]  wshift;
  logic                         off2;
  logic                         hi_en;
  logic [jtdt_pkg::CNT_W-1:0]   bits;
  logic                         in_win;
  logic                         hi_ok;
  logic                         bit_out;

  // Pick the reply bit for the current position
  always_comb begin
    in_win  = off2 ? (idx >= 6'd2 && idx < 6'd34) : !idx[5];
    hi_ok   = hi_en && idx[5] && ({1'b0, idx[5:3], 3'b000} < bits);
    bit_out = (in_win & wshift[0]) | (hi_ok & pshift[0]);
  end

  assign sts.active  = active;
  assign sts.tms_bit = pshift[0];

  // Count bits
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      left   <= '0;
    end else if (ctl.start) begin
      active <= (ctl.cnt != '0);
      left   <= ctl.cnt;
    end else if (active) begin
      left <= left - 7'd1;
      if (left == 7'd1) begin
        active <= 1'b0;
      end
    end
  end

  // Shift payload, word and reply
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      idx    <= '0;
      pshift <= pl;
      wshift <= ctl.word;
      off2   <= ctl.off2;
      hi_en  <= ctl.hi_en;
      bits   <= ctl.bits;
    end else if (active) begin
      idx    <= idx + 6'd1;
      pshift <= {1'b0, pshift[jtdt_pkg::PL_W-1:1]};
      if (in_win) begin
        wshift <= {1'b0, wshift[jtdt_pkg::DATA_W-1:1]};
      end
      reply  <= {bit_out, reply[jtdt_pkg::PL_W-1:1]};
    end
  end

endmodule

[hw/rtl/jtdt_ctrl.sv]
// Command sequencer: TAP state, instruction register, bus handshake and result register.
// Depends on jtdt_pkg, jtdt_if and the bit shifter's status.
module jtdt_ctrl #(
  parameter int MAX_TMS_BITS = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  jtdt_cmd_if.sink                  cmd,
  jtdt_res_if.source                res,
  input  logic [31:0]               id_code,
  input  logic [31:0]               ctrl_word,
  input  jtdt_pkg::eng_sts_t        eng_sts,
  input  logic [jtdt_pkg::PL_W-1:0] eng_reply,
  output jtdt_pkg::eng_ctl_t        eng_ctl
);

  localparam logic [jtdt_pkg::CNT_W-1:0] MaxTms = 7'(MAX_TMS_BITS);

  jtdt_pkg::ctl_state_t state, state_next;

  logic [3:0]                       tap_state;
  logic [3:0]                       pending_state;
  logic [jtdt_pkg::IR_WIDTH-1:0]    instr_reg;
  logic [31:0]                      last_bus_data;
  logic                             bus_busy;
  logic [1:0]                       stage_kind;
  logic [jtdt_pkg::ADDR_WIDTH-1:0]  req_addr;
  logic [31:0]                      req_data;
  logic [1:0]                       req_op;
  logic                             out_valid;

  logic                             accept;
  logic                             emit_ok;
  logic                             act_reset;
  logic                             act_tms;
  logic                             act_scan;
  logic                             act_req;
  logic                             act_unexp;
  logic                             act_resp;
  logic                             ir_load;
  logic [jtdt_pkg::IR_WIDTH-1:0]    ir_next;
  logic [3:0]                       pending_next;
  logic [jtdt_pkg::CNT_W-1:0]       tms_n;
  logic [jtdt_pkg::CNT_W-1:0]       scan_bits;
  logic [1:0]                       dbus_op;

  // Decode the command at the head of the channel
  always_comb begin
    accept       = cmd.valid && cmd.ready;
    emit_ok      = !out_valid || res.ready;
    dbus_op      = cmd.payload[1:0];
    tms_n        = (cmd.bit_count > MaxTms) ? MaxTms : cmd.bit_count;
    scan_bits    = (cmd.bit_count > jtdt_pkg::SCAN_LEN) ? jtdt_pkg::SCAN_LEN : cmd.bit_count;
    pending_next = jtdt_pkg::tap_step(tap_state, cmd.opcode == jtdt_pkg::OP_SCAN_FLIP);
    act_unexp    = (cmd.opcode == jtdt_pkg::OP_BUS_RESP) && !bus_busy;
    act_resp     = (cmd.opcode == jtdt_pkg::OP_BUS_RESP) && bus_busy;
    act_reset    = (cmd.opcode == jtdt_pkg::OP_RESET) && !bus_busy;
    act_tms      = (cmd.opcode == jtdt_pkg::OP_TMS_SEQ) && !bus_busy && (tms_n != '0);
    act_scan     = ((cmd.opcode == jtdt_pkg::OP_SCAN) || (cmd.opcode == jtdt_pkg::OP_SCAN_FLIP))
                   && !bus_busy;
    act_req      = act_scan && (tap_state == jtdt_pkg::TAP_SHIFT_DR)
                   && (instr_reg == jtdt_pkg::INSTR_DBUS)
                   && (dbus_op == jtdt_pkg::BOP_READ || dbus_op == jtdt_pkg::BOP_WRITE);
  end

  // Set up the shifter for the reply
  always_comb begin
    eng_ctl.start = accept && (act_tms || act_resp || (act_scan && !act_req));
    eng_ctl.cnt   = act_tms ? tms_n : jtdt_pkg::SCAN_LEN;
    eng_ctl.word  = '0;
    eng_ctl.off2  = 1'b0;
    eng_ctl.hi_en = 1'b0;
    eng_ctl.bits  = scan_bits;
    ir_load       = 1'b0;
    ir_next       = instr_reg;
    if (act_resp) begin
      eng_ctl.word = cmd.payload[31:0];
      eng_ctl.off2 = 1'b1;
    end else if (tap_state == jtdt_pkg::TAP_SHIFT_DR) begin
      case (instr_reg)
        jtdt_pkg::INSTR_IDCODE: begin
          eng_ctl.word  = id_code;
          eng_ctl.hi_en = 1'b1;
        end
        jtdt_pkg::INSTR_DTMCS: begin
          eng_ctl.word = ctrl_word;
        end
        jtdt_pkg::INSTR_DBUS: begin
          eng_ctl.off2 = 1'b1;
          eng_ctl.word = (dbus_op == jtdt_pkg::BOP_NOP) ? last_bus_data : cmd.payload[33:2];
        end
        default: begin
          eng_ctl.word = '0;
        end
      endcase
    end else if (tap_state == jtdt_pkg::TAP_SHIFT_IR) begin
      if (cmd.bit_count == jtdt_pkg::IR_SCAN_LEN) begin
        eng_ctl.word = {27'd0, instr_reg};
        ir_load      = 1'b1;
        ir_next      = cmd.payload[4:0];
      end else if (cmd.bit_count == jtdt_pkg::IR_SCAN_LEN_LONG) begin
        eng_ctl.word = {25'd0, cmd.payload[1:0], instr_reg};
        ir_load      = 1'b1;
        ir_next      = cmd.payload[6:2];
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      jtdt_pkg::ST_IDLE: begin
        if (accept) begin
          if (act_unexp || act_req) begin
            state_next = jtdt_pkg::ST_EMIT;
          end else if (act_resp || act_scan) begin
            state_next = jtdt_pkg::ST_SCAN;
          end else if (act_tms) begin
            state_next = jtdt_pkg::ST_TMS;
          end
        end
      end
      jtdt_pkg::ST_TMS: begin
        if (!eng_sts.active) begin
          state_next = jtdt_pkg::ST_IDLE;
        end
      end
      jtdt_pkg::ST_SCAN: begin
        if (!eng_sts.active) begin
          state_next = jtdt_pkg::ST_EMIT;
        end
      end
      jtdt_pkg::ST_EMIT: begin
        if (emit_ok) begin
          state_next = jtdt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = jtdt_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd.ready = (state == jtdt_pkg::ST_IDLE);
    res.valid = out_valid;
  end

  // Architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= jtdt_pkg::ST_IDLE;
      tap_state     <= jtdt_pkg::TAP_RESET;
      pending_state <= jtdt_pkg::TAP_RESET;
      instr_reg     <= '0;
      last_bus_data <= '0;
      bus_busy      <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (act_resp) begin
          bus_busy      <= 1'b0;
          last_bus_data <= cmd.payload[31:0];
          tap_state     <= pending_state;
        end else if (act_reset) begin
          tap_state <= jtdt_pkg::TAP_RESET;
          instr_reg <= jtdt_pkg::INSTR_IDCODE;
        end else if (act_req) begin
          pending_state <= pending_next;
          bus_busy      <= 1'b1;
        end else if (act_scan) begin
          pending_state <= pending_next;
          tap_state     <= pending_next;
          if (ir_load) begin
            instr_reg <= ir_next;
          end
        end
      end
      // Step the TAP once per TMS bit
      if (state == jtdt_pkg::ST_TMS && eng_sts.active) begin
        tap_state <= jtdt_pkg::tap_step(tap_state, eng_sts.tms_bit);
      end
    end
  end

  // Hold what the pending result needs
  always_ff @(posedge clk) begin
    if (accept) begin
      stage_kind <= act_unexp ? jtdt_pkg::KIND_UNEXP
                  : act_req   ? jtdt_pkg::KIND_REQ : jtdt_pkg::KIND_SCAN;
      req_addr   <= cmd.payload[39:34];
      req_data   <= cmd.payload[33:2];
      req_op     <= dbus_op;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == jtdt_pkg::ST_EMIT && emit_ok) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == jtdt_pkg::ST_EMIT && emit_ok) begin
      res.result_kind <= stage_kind;
      res.scan_reply  <= (stage_kind == jtdt_pkg::KIND_SCAN) ? eng_reply : '0;
      res.bus_addr    <= (stage_kind == jtdt_pkg::KIND_REQ) ? req_addr : '0;
      res.bus_data    <= (stage_kind == jtdt_pkg::KIND_REQ) ? req_data : '0;
      res.bus_op      <= (stage_kind == jtdt_pkg::KIND_REQ) ? req_op : '0;
    end
  end

endmodule
